FILE: rtl/assert_macros.svh
// Assertion helpers, clocked, quiet while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/fxd_pkg.sv
`default_nettype none
package fxd_pkg;

	localparam int KEY_LEN    = 8;
	localparam int KIDX_W     = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
	localparam int MAGIC_LEN  = 9;
	localparam int MAGIC_IW   = $clog2(MAGIC_LEN);
	localparam int LEN_BYTES  = 8;
	localparam int HEADER_LEN = MAGIC_LEN + LEN_BYTES;
	localparam int HP_W       = 5;

	localparam logic [7:0] MAGIC [MAGIC_LEN] = '{
		8'h45, 8'h4E, 8'h43, 8'h4C, 8'h41, 8'h42, 8'h5F, 8'h56, 8'h31
	};

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_MAGIC = 2'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       done_res;
		logic [1:0] status;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/fxd_in_if.sv
`default_nettype none
interface fxd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/fxd_out_if.sv
`default_nettype none
interface fxd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       done_res;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_valid, output done_res,
		output status, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input done_res,
		input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/fxd_frame.sv
`default_nettype none
// Framing state, length capture and payload XOR for the byte held in stage 1.
module fxd_frame (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [8*8-1:0]        key,
	input  wire logic                  item_v,
	input  wire logic [7:0]            item_byte,
	input  wire logic                  item_last,
	input  wire logic                  room,
	output logic                       adv,
	output logic                       emit,
	output fxd_pkg::res_t              res
);

	logic [fxd_pkg::HP_W-1:0]   hp_q;
	logic                       mgood_q;
	logic [63:0]                len_q;
	logic [63:0]                cnt_q;
	logic [fxd_pkg::KIDX_W-1:0] kidx_q;

	logic                       in_magic;
	logic                       in_len;
	logic [fxd_pkg::HP_W-1:0]   hp_nx;
	logic                       mgood_nx;
	logic [2:0]                 lidx;
	logic                       pay_v;
	logic [7:0]                 kbyte;

	localparam logic [fxd_pkg::HP_W-1:0] HP_MAGIC  = fxd_pkg::HP_W'(fxd_pkg::MAGIC_LEN);
	localparam logic [fxd_pkg::HP_W-1:0] HP_HEADER = fxd_pkg::HP_W'(fxd_pkg::HEADER_LEN);
	localparam logic [fxd_pkg::KIDX_W-1:0] KIDX_TOP =
		fxd_pkg::KIDX_W'(fxd_pkg::KEY_LEN - 1);

	always_comb begin
		in_magic = hp_q < HP_MAGIC;
		in_len   = !in_magic && (hp_q < HP_HEADER);
		lidx     = 3'(hp_q - HP_MAGIC);
		hp_nx    = (in_magic || in_len) ? hp_q + 1'b1 : hp_q;
		mgood_nx = mgood_q;
		if (in_magic && (item_byte != fxd_pkg::MAGIC[hp_q[fxd_pkg::MAGIC_IW-1:0]])) begin
			mgood_nx = 1'b0;
		end
		pay_v = !in_magic && !in_len && mgood_q && (cnt_q < len_q);
		kbyte = key[8*kidx_q +: 8];

		res.out_byte   = pay_v ? (item_byte ^ kbyte) : 8'd0;
		res.byte_valid = pay_v;
		res.done_res   = item_last;
		if (!item_last) begin
			res.status = fxd_pkg::ST_OK;
		end else if (hp_nx < HP_HEADER) begin
			res.status = fxd_pkg::ST_SHORT;
		end else if (!mgood_nx) begin
			res.status = fxd_pkg::ST_MAGIC;
		end else begin
			res.status = fxd_pkg::ST_OK;
		end

		emit = pay_v || item_last;
		adv  = item_v && (!emit || room);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q    <= '0;
			mgood_q <= 1'b1;
			len_q   <= '0;
			cnt_q   <= '0;
			kidx_q  <= '0;
		end else if (adv) begin
			if (item_last) begin
				hp_q    <= '0;
				mgood_q <= 1'b1;
				len_q   <= '0;
				cnt_q   <= '0;
				kidx_q  <= '0;
			end else begin
				hp_q    <= hp_nx;
				mgood_q <= mgood_nx;
				if (in_len) begin
					len_q[8*lidx +: 8] <= item_byte;
				end
				if (!in_magic && !in_len) begin
					cnt_q  <= cnt_q + 64'd1;
					kidx_q <= (kidx_q == KIDX_TOP) ? '0 : kidx_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fxd_skid.sv
`default_nettype none
// Two-entry result buffer; room is a registered view of its fill.
module fxd_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fxd_pkg::res_t push_res,
	output logic               room,
	fxd_out_if.source          result
);

	fxd_pkg::res_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;
	logic          do_push;

	assign room    = (cnt_q != 2'd2);
	assign do_push = push && room;
	assign pop     = (cnt_q != 2'd0) && result.ready;

	assign result.valid      = (cnt_q != 2'd0);
	assign result.out_byte   = ent_q[rd_q].out_byte;
	assign result.byte_valid = ent_q[rd_q].byte_valid;
	assign result.done_res   = ent_q[rd_q].done_res;
	assign result.status     = ent_q[rd_q].status;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/framed_xor_stream_decrypt_unit.sv
// channel   dir  width  carries
// stream    in   8+1    container byte, final-byte flag
// result    out  8+1+1+2  plain byte, byte flag, done flag, status
// key_*     in   64     key write (enable + data), idle only
//
// One beat in per cycle sustained while the result buffer has room; a result passes
// through the stage-1 register, then the two-entry result buffer, before it is
// presented.
// Throughput is set by the single stage-1 slot and the frame counters,
// updated once per beat.
// arst_n clears framing state, key, and the valid flags of both buffers at once.
// A stalled result side fills the buffer, then holds stage 1, then drops
// stream.ready; ready never depends combinationally on result.ready.
`default_nettype none
`include "assert_macros.svh"
module framed_xor_stream_decrypt_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        key_we,
	input  wire logic [63:0] key_wdata,
	fxd_in_if.sink           stream,
	fxd_out_if.source        result
);

	logic [63:0]    key_q;

	// stage 1: accepted beat waiting for the framing logic
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;

	logic           adv;
	logic           emit;
	logic           room;
	logic           accept;
	fxd_pkg::res_t  res;

	// stage 1 frees itself whenever the framing logic retires its beat
	assign stream.ready = !valid_s1 || adv;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_we) begin
			key_q <= key_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream.in_byte;
			last_s1 <= stream.in_last;
		end
	end

	// header walk, length capture, keyed XOR, final status
	fxd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_q),
		.item_v    (valid_s1),
		.item_byte (byte_s1),
		.item_last (last_s1),
		.room      (room),
		.adv       (adv),
		.emit      (emit),
		.res       (res)
	);

	// a beat yields a result only when it is emitted or closes the frame
	fxd_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv && emit),
		.push_res (res),
		.room     (room),
		.result   (result)
	);

	// stage 1 holds its beat until the framing logic takes it
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(byte_s1) && $stable(last_s1), "stage 1 beat lost")
	// every delivered result carries a byte or closes a frame
	`ASSERT_IMPLY(a_res_useful, clk, arst_n, result.valid,
		result.byte_valid || result.done_res, "empty result delivered")
	// no plain byte leaks out on a status-only result
	`ASSERT_IMPLY(a_byte_zero, clk, arst_n, result.valid && !result.byte_valid,
		result.out_byte == 8'd0, "stray byte on status-only result")
	// status only set on the closing result
	`ASSERT_IMPLY(a_status_done, clk, arst_n, result.valid && !result.done_res,
		result.status == fxd_pkg::ST_OK, "status set mid frame")

endmodule
`default_nettype wire

FILE: verif/tb.sv
module tb;

	// Clock and run shape
	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 8;
	// Settle time after the last expected result. A header or unemitted payload beat
	// produces no result, so it may still be in the two-stage pipe when the queue
	// empties.
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 150;  // long result-side hold-off in the pressure phase
	localparam int QUIET_LIMIT   = 2000; // cycles with no beat on either side before giving up
	localparam int PHASE_BEATS   = 112;  // beats per random phase, five phases
	localparam int PRINT_CAP     = 100;

	typedef enum int { FR_GOOD, FR_BAD_MAGIC, FR_SHORT, FR_NOISE } frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic        key_we;
	logic [63:0] key_wdata;

	fxd_in_if  stream_ch ();
	fxd_out_if result_ch ();

	framed_xor_stream_decrypt_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_we    (key_we),
		.key_wdata (key_wdata),
		.stream    (stream_ch),
		.result    (result_ch)
	);

	// Tracks framing state beat by beat and queues the plain bytes and statuses
	// that the block should produce.
	class decrypt_scoreboard;
		logic [63:0]   key;
		logic [4:0]    hdr_pos;
		bit            magic_ok;
		logic [63:0]   orig_len;
		logic [63:0]   payload_idx;
		fxd_pkg::res_t plain_q[$];

		function new();
			key = '0;
			restart_frame();
		endfunction

		function void restart_frame();
			hdr_pos     = '0;
			magic_ok    = 1'b1;
			orig_len    = '0;
			payload_idx = '0;
		endfunction

		function void note_beat(logic [7:0] b, logic last);
			fxd_pkg::res_t exp;
			int            k;
			exp = '0;
			if (hdr_pos < fxd_pkg::MAGIC_LEN) begin
				if (b != fxd_pkg::MAGIC[hdr_pos])
					magic_ok = 1'b0;
				hdr_pos++;
			end else if (hdr_pos < fxd_pkg::HEADER_LEN) begin
				orig_len |= 64'(b) << (8 * (hdr_pos - fxd_pkg::MAGIC_LEN));
				hdr_pos++;
			end else begin
				if (magic_ok && payload_idx < orig_len) begin
					k              = int'(payload_idx % fxd_pkg::KEY_LEN);
					exp.out_byte   = b ^ key[8*k +: 8];
					exp.byte_valid = 1'b1;
				end
				payload_idx++;
			end
			if (!exp.byte_valid && !last)
				return;
			if (last) begin
				exp.done_res = 1'b1;
				// too short wins over a bad magic
				if (hdr_pos < fxd_pkg::HEADER_LEN)
					exp.status = fxd_pkg::ST_SHORT;
				else if (!magic_ok)
					exp.status = fxd_pkg::ST_MAGIC;
				else
					exp.status = fxd_pkg::ST_OK;
				restart_frame();
			end
			plain_q.push_back(exp);
		endfunction

		// Empty string when the beat matches the oldest expectation.
		function string check_beat(fxd_pkg::res_t got);
			fxd_pkg::res_t exp;
			string         why;
			if (plain_q.size() == 0)
				return $sformatf(" result beat with nothing outstanding: %h", got);
			exp = plain_q.pop_front();
			why = "";
			if (got.out_byte !== exp.out_byte)
				why = {why, $sformatf(" out_byte %02h exp %02h", got.out_byte, exp.out_byte)};
			if (got.byte_valid !== exp.byte_valid)
				why = {why, $sformatf(" byte_valid %b exp %b", got.byte_valid, exp.byte_valid)};
			if (got.done_res !== exp.done_res)
				why = {why, $sformatf(" done_res %b exp %b", got.done_res, exp.done_res)};
			if (got.status !== exp.status)
				why = {why, $sformatf(" status %0d exp %0d", got.status, exp.status)};
			return why;
		endfunction
	endclass

	decrypt_scoreboard sb;
	int                mismatches;
	int                beats_sent;
	int                quiet_cycles;
	int                src_idle_pct;
	int                sink_stall_pct;
	bit                hold_req;

	task automatic report_mismatch(input string why);
		if (mismatches < PRINT_CAP)
			$display("ERROR at %0t:%s", $time, why);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Result side: random stalls per phase, or one long hold-off on request.
	// The hold-off is counted here so the sender keeps offering beats meanwhile.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// Sample both handshakes at the rising edge; DUT updates land after this.
	// Also the watchdog: too long with no beat either way ends the run.
	always @(posedge clk) begin
		fxd_pkg::res_t got;
		string         why;
		if (arst_n) begin
			if (stream_ch.valid && stream_ch.ready)
				sb.note_beat(stream_ch.in_byte, stream_ch.in_last);
			if (result_ch.valid && result_ch.ready) begin
				got.out_byte   = result_ch.out_byte;
				got.byte_valid = result_ch.byte_valid;
				got.done_res   = result_ch.done_res;
				got.status     = result_ch.status;
				why = sb.check_beat(got);
				if (why != "")
					report_mismatch(why);
			end
			if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("framed_xor_stream_decrypt_unit test failed");
				$finish;
			end
		end
	end

	// One beat on the stream channel; returns at the falling edge after acceptance
	// with valid still high, so back-to-back beats need no gap.
	task automatic send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stream_ch.valid   <= 1'b1;
		stream_ch.in_byte <= b;
		stream_ch.in_last <= last;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_container(input frame_kind_t kind);
		logic [7:0]  frame_q[$];
		logic [63:0] len_field;
		int          plen;
		int          n;
		int          i;
		int          r;
		case (kind)
		FR_GOOD, FR_BAD_MAGIC: begin
			for (i = 0; i < fxd_pkg::MAGIC_LEN; i++)
				frame_q.push_back(fxd_pkg::MAGIC[i]);
			if (kind == FR_BAD_MAGIC) begin
				r = $urandom_range(0, fxd_pkg::MAGIC_LEN - 1);
				frame_q[r] = frame_q[r] ^ 8'($urandom_range(1, 255));
			end
			// mostly short payloads; some long enough to wrap the key several times
			r = $urandom_range(0, 99);
			if (r < 5)
				plen = 0;
			else if (r < 85)
				plen = $urandom_range(1, 20);
			else
				plen = $urandom_range(21, 48);
			// length field: exact, truncating, beyond the payload, or wild
			r = $urandom_range(0, 99);
			if (r < 40)
				len_field = 64'(plen);
			else if (r < 65)
				len_field = 64'($urandom_range(0, plen));
			else if (r < 85)
				len_field = 64'(plen + $urandom_range(1, 10));
			else if (r < 95)
				len_field = {$urandom, $urandom};
			else
				len_field = '1;
			for (i = 0; i < fxd_pkg::LEN_BYTES; i++)
				frame_q.push_back(len_field[8*i +: 8]);
			repeat (plen) frame_q.push_back(8'($urandom));
		end
		FR_SHORT: begin
			// ends inside the header, magic intact or not
			n = $urandom_range(1, fxd_pkg::HEADER_LEN - 1);
			for (i = 0; i < n; i++) begin
				if (i < fxd_pkg::MAGIC_LEN)
					frame_q.push_back(fxd_pkg::MAGIC[i]);
				else
					frame_q.push_back(8'($urandom));
			end
			if ($urandom_range(0, 1))
				frame_q[$urandom_range(0, n - 1)] = 8'($urandom);
		end
		default: begin
			repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
		end
		endcase
		foreach (frame_q[j])
			send_beat(frame_q[j], j == frame_q.size() - 1);
	endtask

	// Sender pauses until every expected beat has come back, then lets any
	// result-less beats clear the pipe. Leaves the block idle for a key write.
	task automatic drain();
		stream_ch.valid <= 1'b0;
		while (sb.plain_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_key(input logic [63:0] value);
		key_we    <= 1'b1;
		key_wdata <= value;
		@(negedge clk);
		key_we    <= 1'b0;
		sb.key = value;
	endtask

	task automatic run_phase(input int src_pct, input int snk_pct, input logic [63:0] key_value,
			input bit hold);
		int target;
		int r;
		src_idle_pct   = src_pct;
		sink_stall_pct = snk_pct;
		write_key(key_value);
		if (hold)
			hold_req = 1'b1;
		target = beats_sent + PHASE_BEATS;
		while (beats_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_container(FR_GOOD);
			else if (r < 80)
				send_container(FR_BAD_MAGIC);
			else if (r < 90)
				send_container(FR_SHORT);
			else
				send_container(FR_NOISE);
		end
		drain();
	endtask

	initial begin
		int i;
		arst_n            = 1'b0;
		key_we            = 1'b0;
		key_wdata         = '0;
		stream_ch.valid   = 1'b0;
		stream_ch.in_byte = '0;
		stream_ch.in_last = 1'b0;
		hold_req          = 1'b0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		mismatches        = 0;
		beats_sent        = 0;
		quiet_cycles      = 0;
		sb = new();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: two one-beat containers (short beats bad magic), then a good
		// container with length 2 whose final payload beat is past the length.
		write_key(64'hF0E1_D2C3_B4A5_9687);
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b1);
		for (i = 0; i < fxd_pkg::MAGIC_LEN; i++)
			send_beat(fxd_pkg::MAGIC[i], 1'b0);
		send_beat(8'h02, 1'b0);
		repeat (fxd_pkg::LEN_BYTES - 1) send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hA5, 1'b1);
		drain();

		// Random phases: no idling, sender gaps, result stalls, both, then the
		// long hold-off that backs the block up into the stream side.
		run_phase(0,  0,  {$urandom, $urandom}, 1'b0);
		run_phase(69, 0,  64'h0,                1'b0);
		run_phase(0,  69, '1,                   1'b0);
		run_phase(19, 19, {$urandom, $urandom}, 1'b0);
		run_phase(0,  0,  64'h55AA_33CC_0FF0_9669, 1'b1);

		if (sb.plain_q.size() != 0)
			report_mismatch($sformatf(" %0d result beat(s) never arrived", sb.plain_q.size()));
		if (mismatches == 0)
			$display("framed_xor_stream_decrypt_unit test passed");
		else
			$display("framed_xor_stream_decrypt_unit test failed");
		$finish;
	end

endmodule
